@@ rtl/fhg_pkg.sv @@
// Shared types, widths and constants of the IPv4 fragment header generator.
`default_nettype none

package fhg_pkg;

    localparam int LEN_W    = 16;
    localparam int MTU_W    = 11;
    localparam int OFF_W    = 13;
    localparam int CSUM_W   = 16;
    localparam int IN_W     = 120;
    localparam int OUT_W    = 72;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [MTU_W-1:0]  MTU_MIN   = 11'd1044;
    localparam logic [MTU_W-1:0]  MTU_MAX   = 11'd1500;
    localparam logic [MTU_W-1:0]  MTU_RST   = 11'd1500;
    localparam logic [MTU_W-1:0]  HDR_BYTES = 11'd20;
    localparam logic [CSUM_W-1:0] VER_IHL   = 16'h4500;

    localparam logic REG_MTU = 1'b0;

    typedef struct packed {
        logic load;
        logic sum;
        logic emit;
        logic err;
    } t_cmd;

    typedef struct packed {
        logic zero_len;
        logic too_long;
        logic last_frag;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

@@ rtl/ipv4_fragment_header_generator_unit.sv @@
// Top level of the IPv4 fragment header generator: MTU register, controller, datapath.
//
// Usage:
//   A send request enters on the s_ stream channel; one header result per
//   fragment leaves on the m_ stream channel, m_tlast marking the final
//   result of the request. A request with DF set and a payload longer than
//   MTU-20 gives one result with m_tuser high and all data bits zero. A
//   zero-length request gives no result.
//   The MTU register sits at byte address 0 of the APB port; values outside
//   1044..1500 are clamped. Write it only while the block is idle.
// Timing:
//   The first result is registered once the request is loaded and its header
//   sum formed; further fragments follow one per cycle while the output
//   register is free, set by the single fragment sequencer. A request of N
//   fragments (N at most 64) occupies the block to the end; s_tready is high only
//   while the controller is idle. When m_tready is low the output register
//   holds its result and the sequencer waits. Reset clears the controller and
//   output valid and sets the MTU to 1500.
`default_nettype none

module ipv4_fragment_header_generator_unit (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // APB register port
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [fhg_pkg::APB_AW-1:0]    paddr,
    input  wire [fhg_pkg::APB_DW-1:0]    pwdata,
    output logic [fhg_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    // request channel
    input  wire                          s_tvalid,
    output logic                         s_tready,
    // payload_len[15:0], packet_id[31:16], dont_fragment[32], time_to_live[40:33],
    // protocol[48:41], src_addr[80:49], dst_addr[112:81], zero fill[119:113]
    input  wire [fhg_pkg::IN_W-1:0]      s_tdata,
    // result channel
    output logic                         m_tvalid,
    input  wire                          m_tready,
    // total_length[10:0], fragment_offset[23:11], more_fragments[24],
    // df_flag[25], header_checksum[41:26], payload_start[57:42],
    // slice_len[68:58], zero fill[71:69]
    output logic [fhg_pkg::OUT_W-1:0]    m_tdata,
    // too_long[0]
    output logic                         m_tuser,
    output logic                         m_tlast
);
    import fhg_pkg::*;

    logic [MTU_W-1:0] r_mtu;
    logic [MTU_W-1:0] mtu_clamped;
    logic [MTU_W-1:0] room;
    t_cmd             cmd;
    t_stat            stat;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mtu <= MTU_RST;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MTU)) begin
            r_mtu <= pwdata[MTU_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_MTU) begin
            prdata = {{(APB_DW-MTU_W){1'b0}}, r_mtu};
        end
    end

    assign mtu_clamped = (r_mtu < MTU_MIN) ? MTU_MIN :
                         (r_mtu > MTU_MAX) ? MTU_MAX : r_mtu;
    assign room        = mtu_clamped - HDR_BYTES;

    fhg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_tvalid),
        .o_req_ready (s_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    fhg_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (s_tdata),
        .i_room  (room),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_data  (m_tdata),
        .o_user  (m_tuser),
        .o_last  (m_tlast)
    );

endmodule

`default_nettype wire

@@ rtl/fhg_ctrl.sv @@
// Controller state machine: request intake, header sum, fragment sequencing, error result.
`default_nettype none

module fhg_ctrl (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_req_valid,
    output logic          o_req_ready,
    input  fhg_pkg::t_stat i_stat,
    output fhg_pkg::t_cmd  o_cmd
);
    import fhg_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SUM  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;
    localparam logic [1:0] ST_ERR  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_req_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SUM;
                end
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                if (i_stat.zero_len) begin
                    n_state = ST_IDLE;
                end else if (i_stat.too_long) begin
                    n_state = ST_ERR;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.last_frag) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_ERR: begin
                if (i_stat.out_free) begin
                    o_cmd.err = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ rtl/fhg_dp.sv @@
// Datapath: request registers, fragment counters, checksum and output register.
`default_nettype none

module fhg_dp (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire [fhg_pkg::IN_W-1:0]    i_req,
    input  wire [fhg_pkg::MTU_W-1:0]   i_room,
    input  fhg_pkg::t_cmd              i_cmd,
    output fhg_pkg::t_stat             o_stat,
    output logic                       o_valid,
    input  wire                        i_ready,
    output logic [fhg_pkg::OUT_W-1:0]  o_data,
    output logic                       o_user,
    output logic                       o_last
);
    import fhg_pkg::*;

    logic [LEN_W-1:0]  r_rest;
    logic [LEN_W-1:0]  r_start;
    logic [15:0]       r_id;
    logic              r_df;
    logic [7:0]        r_ttl;
    logic [7:0]        r_proto;
    logic [31:0]       r_src;
    logic [31:0]       r_dst;
    logic [MTU_W-1:0]  r_room;
    logic [MTU_W-1:0]  r_chunk;
    logic [CSUM_W-1:0] r_base;

    logic              r_ovalid;
    logic [OUT_W-1:0]  r_odata;
    logic              r_ouser;
    logic              r_olast;

    logic              last_frag;
    logic [MTU_W-1:0]  slice;
    logic              mf;
    logic [OFF_W-1:0]  off;
    logic [MTU_W-1:0]  total;
    logic [15:0]       flags_off;
    logic [17:0]       frag_sum;
    logic [16:0]       frag_f1;
    logic [15:0]       frag_f2;
    logic [18:0]       base_sum;
    logic [16:0]       base_f1;
    logic [15:0]       base_f2;

    // fixed header words, folded once per request
    assign base_sum = {3'b0, VER_IHL} + {3'b0, r_id} + {3'b0, r_ttl, r_proto}
                    + {3'b0, r_src[31:16]} + {3'b0, r_src[15:0]}
                    + {3'b0, r_dst[31:16]} + {3'b0, r_dst[15:0]};
    assign base_f1  = {1'b0, base_sum[15:0]} + {14'b0, base_sum[18:16]};
    assign base_f2  = base_f1[15:0] + {15'b0, base_f1[16]};

    assign last_frag = (r_rest <= {{(LEN_W-MTU_W){1'b0}}, r_room});
    assign slice     = last_frag ? r_rest[MTU_W-1:0] : r_chunk;
    assign mf        = !last_frag && !r_df;
    assign off       = r_df ? '0 : r_start[LEN_W-1:3];
    assign total     = HDR_BYTES + slice;
    assign flags_off = {1'b0, r_df, mf, off};

    assign frag_sum = {2'b0, r_base} + {7'b0, total} + {2'b0, flags_off};
    assign frag_f1  = {1'b0, frag_sum[15:0]} + {15'b0, frag_sum[17:16]};
    assign frag_f2  = frag_f1[15:0] + {15'b0, frag_f1[16]};

    assign o_stat.zero_len  = (r_rest == '0);
    assign o_stat.too_long  = r_df && (r_rest > {{(LEN_W-MTU_W){1'b0}}, r_room});
    assign o_stat.last_frag = last_frag;
    assign o_stat.out_free  = !r_ovalid || i_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rest  <= i_req[15:0];
            r_id    <= i_req[31:16];
            r_df    <= i_req[32];
            r_ttl   <= i_req[40:33];
            r_proto <= i_req[48:41];
            r_src   <= i_req[80:49];
            r_dst   <= i_req[112:81];
            r_start <= '0;
            r_room  <= i_room;
            r_chunk <= {i_room[MTU_W-1:3], 3'b000};
        end
        if (i_cmd.sum) begin
            r_base <= base_f2;
        end
        if (i_cmd.emit) begin
            // advance to the next slice
            r_rest  <= r_rest - {{(LEN_W-MTU_W){1'b0}}, slice};
            r_start <= r_start + {{(LEN_W-MTU_W){1'b0}}, slice};
            r_odata <= {3'b0, slice, r_start, ~frag_f2, r_df, mf, off, total};
            r_ouser <= 1'b0;
            r_olast <= last_frag;
        end else if (i_cmd.err) begin
            r_odata <= '0;
            r_ouser <= 1'b1;
            r_olast <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.err) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
    assign o_user  = r_ouser;
    assign o_last  = r_olast;

endmodule

`default_nettype wire

@@ rtl/fhg_checker.sv @@
// Port-level assertions for the IPv4 fragment header generator, bound to the top level.
`default_nettype none

module fhg_checker (
    input wire                        i_clk,
    input wire                        i_rst_n,
    input wire                        s_tready,
    input wire                        m_tvalid,
    input wire                        m_tready,
    input wire [fhg_pkg::OUT_W-1:0]   m_tdata,
    input wire                        m_tuser,
    input wire                        m_tlast
);
    import fhg_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // an error result ends its request and carries no header
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == '0))
        else $error("error result malformed");

    // total length is header plus slice
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser |-> m_tdata[10:0] == m_tdata[68:58] + HDR_BYTES)
        else $error("total length mismatch");

    // no new request while a request still has fragments to give
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("request taken mid-sequence");

endmodule

bind ipv4_fragment_header_generator_unit fhg_checker u_fhg_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
